FILE: rtl/indexed_bank_switch_mapper_unit_macros.svh
// Assertion macros for the mapper RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef INDEXED_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH
`define INDEXED_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define IBSM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibsm assertion failed")
// Next-cycle implication, disabled while reset is asserted.
`define IBSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibsm assertion failed")
`else
`define IBSM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define IBSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ibsm_pkg.sv
// Shared types and constants for the indexed bank switch mapper.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package ibsm_pkg;

    localparam logic [15:0] ADDR_INDEX = 16'h4100;
    localparam logic [15:0] ADDR_DATA  = 16'h4101;

    // Mapper register indices selected by a write to the index address.
    localparam logic [7:0] REG_CHR0   = 8'd0;
    localparam logic [7:0] REG_CHR1   = 8'd1;
    localparam logic [7:0] REG_CHR2   = 8'd2;
    localparam logic [7:0] REG_CHR3   = 8'd3;
    localparam logic [7:0] REG_MODE_A = 8'd4;
    localparam logic [7:0] REG_PRG    = 8'd5;
    localparam logic [7:0] REG_MODE_B = 8'd6;
    localparam logic [7:0] REG_MIRROR = 8'd7;

    // Configuration register indices.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR   = 2'd2;

    localparam int PRG_W   = 9;
    localparam int CHR_W   = 11;
    localparam int DVD_W   = 8;
    localparam int LANES   = 4;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [PRG_W-1:0] prg_page0;
        logic [PRG_W-1:0] prg_page1;
        logic [PRG_W-1:0] prg_page2;
        logic [PRG_W-1:0] prg_page3;
        logic [CHR_W-1:0] chr_page0;
        logic [CHR_W-1:0] chr_page1;
        logic [CHR_W-1:0] chr_page2;
        logic [CHR_W-1:0] chr_page3;
        logic [CHR_W-1:0] chr_fixed_base;
        logic             chr_present;
        logic             mirror_mode;
    } t_out_item;

    typedef struct packed {
        logic accept;     // apply the bus write to mapper state
        logic prg_load;   // seed lanes with PRG page numbers
        logic chr_load;   // seed lanes with CHR bank numbers
        logic step;       // one restoring-division step on all lanes
        logic prg_store;  // capture lane remainders as PRG pages
        logic out_load;   // capture the result into the output register
    } t_cmd;

    typedef struct packed {
        logic prg_req;    // pending bus write selects new PRG pages
    } t_status;

endpackage

FILE: rtl/ibsm_dp.sv
// Mapper datapath: config and mapper registers, four remainder lanes, output register.
// Depends on ibsm_pkg; driven by ibsm_ctrl commands.
`timescale 1ns / 1ps

module ibsm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ibsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                        i_cfg_data,
    input  ibsm_pkg::t_in_item                i_item,
    input  ibsm_pkg::t_cmd                    i_cmd,
    output ibsm_pkg::t_status                 o_status,
    output ibsm_pkg::t_out_item               o_item
);
    import ibsm_pkg::*;

    logic [7:0]       r_prg_size;
    logic [7:0]       r_chr_size;
    logic             r_init_mirror;
    logic [7:0]       r_reg_index;
    logic [7:0]       r_chr_low [LANES];
    logic             r_mode_a;
    logic [2:0]       r_mode_b;
    logic [2:0]       r_prg_base;
    logic [PRG_W-1:0] r_prg_pages [LANES];
    logic             r_mirror;
    logic             r_mirror_written;

    logic [CHR_W-1:0] r_rem [LANES];
    logic [DVD_W-1:0] r_dvd [LANES];
    logic [CHR_W-1:0] r_div;
    t_out_item        r_out;

    logic [7:0]       prg_size_eff;
    logic [CHR_W-1:0] prg_count;
    logic [CHR_W-1:0] chr_count;
    logic [DVD_W-1:0] chr_bank [LANES];
    logic [CHR_W:0]   shifted [LANES];
    logic [CHR_W:0]   diff [LANES];
    logic [CHR_W-1:0] n_rem [LANES];
    logic             chr_present;

    assign o_status.prg_req = (i_item.bus_address == ADDR_DATA) && (r_reg_index == REG_PRG);

    assign prg_size_eff = (r_prg_size == 8'd0) ? 8'd1 : r_prg_size;
    assign prg_count    = {2'b00, prg_size_eff, 1'b0};
    assign chr_count    = {r_chr_size, 3'b000};
    assign chr_present  = (r_chr_size != 8'd0);

    assign chr_bank[0] = r_chr_low[0];
    assign chr_bank[1] = r_chr_low[1] | {4'b0000, r_mode_b[0], 3'b000};
    assign chr_bank[2] = r_chr_low[2] | {4'b0000, r_mode_b[1], 3'b000};
    assign chr_bank[3] = r_chr_low[3] | {3'b000, r_mode_a, r_mode_b[2], 3'b000};

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            shifted[k] = {r_rem[k], r_dvd[k][DVD_W-1]};
            diff[k]    = shifted[k] - {1'b0, r_div};
            n_rem[k]   = (shifted[k] >= {1'b0, r_div}) ? diff[k][CHR_W-1:0]
                                                       : shifted[k][CHR_W-1:0];
        end
    end

    // Mapper state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_size       <= 8'd1;
            r_chr_size       <= 8'd0;
            r_init_mirror    <= 1'b0;
            r_reg_index      <= 8'd0;
            r_mode_a         <= 1'b0;
            r_mode_b         <= 3'd0;
            r_prg_base       <= 3'd0;
            r_mirror         <= 1'b0;
            r_mirror_written <= 1'b0;
            for (int k = 0; k < LANES; k++) begin
                r_chr_low[k]   <= 8'd0;
                r_prg_pages[k] <= PRG_W'(k);
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PRG_SIZE: r_prg_size    <= i_cfg_data;
                    CFG_CHR_SIZE: r_chr_size    <= i_cfg_data;
                    CFG_MIRROR:   r_init_mirror <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                if (i_item.bus_address == ADDR_INDEX) begin
                    r_reg_index <= i_item.write_data;
                end else if (i_item.bus_address == ADDR_DATA) begin
                    unique case (r_reg_index) inside
                        REG_CHR0, REG_CHR1, REG_CHR2, REG_CHR3:
                            r_chr_low[r_reg_index[1:0]] <= i_item.write_data;
                        REG_MODE_A: r_mode_a   <= i_item.write_data[0];
                        REG_PRG:    r_prg_base <= i_item.write_data[2:0];
                        REG_MODE_B: r_mode_b   <= i_item.write_data[2:0];
                        REG_MIRROR: begin
                            r_mirror         <= ~i_item.write_data[0];
                            r_mirror_written <= 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            if (i_cmd.prg_store) begin
                for (int k = 0; k < LANES; k++) begin
                    r_prg_pages[k] <= r_rem[k][PRG_W-1:0];
                end
            end
        end
    end

    // Remainder lanes: restoring division, one dividend bit per step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.prg_load) begin
            r_div <= prg_count;
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= '0;
                r_dvd[k] <= {5'b00000, r_prg_base} + DVD_W'(k);
            end
        end else if (i_cmd.chr_load) begin
            r_div <= chr_count;
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= '0;
                r_dvd[k] <= chr_bank[k];
            end
        end else if (i_cmd.step) begin
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= n_rem[k];
                r_dvd[k] <= {r_dvd[k][DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.prg_page0      <= r_prg_pages[0];
            r_out.prg_page1      <= r_prg_pages[1];
            r_out.prg_page2      <= r_prg_pages[2];
            r_out.prg_page3      <= r_prg_pages[3];
            r_out.chr_page0      <= chr_present ? r_rem[0] : '0;
            r_out.chr_page1      <= chr_present ? r_rem[1] : '0;
            r_out.chr_page2      <= chr_present ? r_rem[2] : '0;
            r_out.chr_page3      <= chr_present ? r_rem[3] : '0;
            r_out.chr_fixed_base <= chr_present ? (chr_count - CHR_W'(4)) : '0;
            r_out.chr_present    <= chr_present;
            r_out.mirror_mode    <= r_mirror_written ? r_mirror : r_init_mirror;
        end
    end

    assign o_item = r_out;

endmodule

FILE: rtl/ibsm_ctrl.sv
// Mapper controller: sequences the PRG and CHR division passes and the output handshake.
// Depends on ibsm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "indexed_bank_switch_mapper_unit_macros.svh"

module ibsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ibsm_pkg::t_status i_status,
    output ibsm_pkg::t_cmd    o_cmd
);
    import ibsm_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PRG_LOAD = 3'd1;
    localparam logic [2:0] S_PRG_STEP = 3'd2;
    localparam logic [2:0] S_CHR_LOAD = 3'd3;
    localparam logic [2:0] S_CHR_STEP = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_prg_run, n_prg_run;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    t_cmd             cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.prg_load  = (r_state == S_PRG_LOAD);
        cmd.chr_load  = (r_state == S_CHR_LOAD);
        cmd.prg_store = (r_state == S_CHR_LOAD) && r_prg_run;
        cmd.step      = (r_state == S_PRG_STEP) || (r_state == S_CHR_STEP);
        cmd.out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_prg_run   = r_prg_run;
        n_out_valid = cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_prg_run = i_status.prg_req;
                    n_state   = i_status.prg_req ? S_PRG_LOAD : S_CHR_LOAD;
                end
            end
            S_PRG_LOAD: begin
                n_cnt   = '0;
                n_state = S_PRG_STEP;
            end
            S_PRG_STEP: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_CHR_LOAD;
                end
            end
            S_CHR_LOAD: begin
                n_cnt     = '0;
                n_prg_run = 1'b0;
                n_state   = S_CHR_STEP;
            end
            S_CHR_STEP: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (cmd.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_prg_run   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_prg_run   <= n_prg_run;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `IBSM_ASSERT_IMPLIES(a_out_slot_free, i_clk, i_rst_n, cmd.out_load, (!r_out_valid || i_out_ready));
    `IBSM_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, (r_state != S_IDLE));
    `IBSM_ASSERT_NEXT(a_prg_pass_to_chr, i_clk, i_rst_n, (r_state == S_PRG_STEP && r_cnt == CNT_LAST), (r_state == S_CHR_LOAD && r_prg_run));
    `IBSM_ASSERT_IMPLIES(a_store_only_after_prg, i_clk, i_rst_n, cmd.prg_store, (r_state == S_CHR_LOAD));

endmodule

FILE: rtl/indexed_bank_switch_mapper_unit.sv
// Top level of the indexed bank switch mapper: ports, config handshake, controller and datapath.
// Depends on ibsm_pkg, ibsm_ctrl and ibsm_dp.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  --------------------------------
//  in        sink       i_in_valid / o_in_ready   i_in_item  (bus address, data)
//  out       source     o_out_valid / i_out_ready o_out_item (PRG/CHR pages, mirror)
//  cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One item at a time, accepted only while idle; the PRG pass runs only for a data
//  write to the PRG select register. Four remainder lanes retire one dividend bit per
//  cycle, 8 steps for the CHR banks and, when selected, a load and 8 more for PRG pages.
//  Reset is synchronous and active low; it restores sizes, mirroring and pages.
//  A stalled output holds its register while the next item is processed; that item then
//  waits in its final state. The config port is always ready; write it only while idle.

module indexed_bank_switch_mapper_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ibsm_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ibsm_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ibsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import ibsm_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Register writes go straight into the config registers; never stall the config channel.
    assign o_cfg_ready = 1'b1;

    ibsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ibsm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_item      (o_out_item)
    );

endmodule

FILE: test/indexed_bank_switch_mapper_unit_tb.sv
// Self-checking testbench for the indexed bank switch mapper top level.
// Depends on ibsm_pkg and indexed_bank_switch_mapper_unit; predicts each result
// from a behavioral model of the mapper registers and checks it field by field.
`timescale 1ns / 1ps

module indexed_bank_switch_mapper_unit_tb;
    import ibsm_pkg::*;

    // Mapper indices above the last defined register; writes through them are dropped.
    localparam logic [7:0] REG_FIRST_UNUSED = 8'd8;
    localparam logic [7:0] REG_LAST_UNUSED  = 8'hFF;
    // Config index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int END_SETTLE     = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    indexed_bank_switch_mapper_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Mapper model: configuration copy and register state.
    // ------------------------------------------------------------------
    logic [7:0] cfg_prg_size;
    logic [7:0] cfg_chr_size;
    logic       cfg_mirror;

    logic [7:0]       sel_index;
    logic [7:0]       chr_low [4];
    logic             mode_a;
    logic [2:0]       mode_b;
    logic [PRG_W-1:0] prg_sel [4];
    logic             mirror_reg;
    logic             mirror_seen;

    // Expected mapping after each accepted bus write, oldest first.
    t_out_item pending_maps[$];

    int writes_sent;
    int maps_checked;
    int mismatches;
    int configs_used;
    int idle_cycles;

    // Idle percentages for the bus write source and the result sink.
    int tx_idle_pct;
    int rx_idle_pct;

    // Toggle to ask the sink for one long hold-off.
    logic holdoff_req;
    logic holdoff_ack;
    int   hold_left;

    // ------------------------------------------------------------------
    // Clock and stall watchdog.
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Count cycles with no handshake on any channel; abort when the block hangs.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("** indexed_bank_switch_mapper_unit: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Model update: apply one bus write and return the mapping it yields.
    // ------------------------------------------------------------------
    function automatic t_out_item map_bus_write(input t_in_item wr);
        t_out_item   res;
        int unsigned prg_count;
        int unsigned chr_count;
        int unsigned bank0, bank1, bank2, bank3;

        if (wr.bus_address == ADDR_INDEX) begin
            sel_index = wr.write_data;
        end else if (wr.bus_address == ADDR_DATA) begin
            if (sel_index <= REG_CHR3) begin
                chr_low[sel_index[1:0]] = wr.write_data;
            end else begin
                case (sel_index)
                    REG_MODE_A: begin
                        mode_a = wr.write_data[0];
                    end
                    REG_PRG: begin
                        // Zero size behaves as one 16 KB unit; four pages in a row, wrapped.
                        prg_count = (cfg_prg_size == 0) ? 2 : 2 * cfg_prg_size;
                        for (int k = 0; k < LANES; k++) begin
                            prg_sel[k] = PRG_W'((wr.write_data[2:0] + k) % prg_count);
                        end
                    end
                    REG_MODE_B: begin
                        mode_b = wr.write_data[2:0];
                    end
                    REG_MIRROR: begin
                        mirror_reg  = ~wr.write_data[0];
                        mirror_seen = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end

        res = '0;
        res.prg_page0 = prg_sel[0];
        res.prg_page1 = prg_sel[1];
        res.prg_page2 = prg_sel[2];
        res.prg_page3 = prg_sel[3];
        if (cfg_chr_size != 0) begin
            chr_count = 8 * cfg_chr_size;
            bank0 = chr_low[0];
            bank1 = chr_low[1] | (mode_b[0] << 3);
            bank2 = chr_low[2] | (mode_b[1] << 3);
            bank3 = chr_low[3] | (mode_b[2] << 3) | (mode_a << 4);
            res.chr_page0      = CHR_W'(bank0 % chr_count);
            res.chr_page1      = CHR_W'(bank1 % chr_count);
            res.chr_page2      = CHR_W'(bank2 % chr_count);
            res.chr_page3      = CHR_W'(bank3 % chr_count);
            res.chr_fixed_base = CHR_W'(chr_count - 4);
            res.chr_present    = 1'b1;
        end
        // Mirroring follows the config value until the mirror register is written once.
        res.mirror_mode = mirror_seen ? mirror_reg : cfg_mirror;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result sink: random idling plus an on-demand long hold-off.
    // ------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        holdoff_ack = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req != holdoff_ack) begin
                holdoff_ack = holdoff_req;
                hold_left   = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left   = hold_left - 1;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted item with the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(input string label, input logic [CHR_W-1:0] want,
                               input logic [CHR_W-1:0] got);
        if (got !== want) begin
            mismatches = mismatches + 1;
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_maps.size() == 0) begin
                mismatches = mismatches + 1;
                $display("%0t: result with no write outstanding, actual %h",
                         $time, o_out_item);
            end else begin
                want = pending_maps.pop_front();
                maps_checked = maps_checked + 1;
                check_field("prg_page0", want.prg_page0, o_out_item.prg_page0);
                check_field("prg_page1", want.prg_page1, o_out_item.prg_page1);
                check_field("prg_page2", want.prg_page2, o_out_item.prg_page2);
                check_field("prg_page3", want.prg_page3, o_out_item.prg_page3);
                check_field("chr_page0", want.chr_page0, o_out_item.chr_page0);
                check_field("chr_page1", want.chr_page1, o_out_item.chr_page1);
                check_field("chr_page2", want.chr_page2, o_out_item.chr_page2);
                check_field("chr_page3", want.chr_page3, o_out_item.chr_page3);
                check_field("chr_fixed_base", want.chr_fixed_base, o_out_item.chr_fixed_base);
                check_field("chr_present", want.chr_present, o_out_item.chr_present);
                check_field("mirror_mode", want.mirror_mode, o_out_item.mirror_mode);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers. All are entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Offer one bus write; keep valid high into the next write when no gap is drawn.
    task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
        t_in_item wr;
        int       gap;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 25);
            repeat (gap) @(negedge i_clk);
        end
        wr.bus_address = addr;
        wr.write_data  = data;
        i_in_item  = wr;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_maps.push_back(map_bus_write(wr));
        writes_sent = writes_sent + 1;
        @(negedge i_clk);
    endtask

    // Select a mapper register, then write it.
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        send_write(ADDR_INDEX, idx);
        send_write(ADDR_DATA, data);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_maps.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write one config register; the block must be idle.
    task automatic set_config(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PRG_SIZE: cfg_prg_size = data;
            CFG_CHR_SIZE: cfg_chr_size = data;
            CFG_MIRROR:   cfg_mirror   = data[0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [7:0] prg, input logic [7:0] chr,
                             input logic [7:0] mirror);
        drain();
        set_config(CFG_PRG_SIZE, prg);
        set_config(CFG_CHR_SIZE, chr);
        set_config(CFG_MIRROR, mirror);
        configs_used = configs_used + 1;
    endtask

    // One random burst: mostly index-then-data pairs, some lone writes and bus noise.
    // Returns the number of bus writes it made.
    task automatic random_burst(output int made);
        int          pick;
        logic [7:0]  idx;
        pick = $urandom_range(99);
        if (pick < 80) begin
            idx = ($urandom_range(99) < 90) ? 8'($urandom_range(0, 7))
                                            : 8'($urandom_range(8, 255));
            write_reg(idx, 8'($urandom));
            made = 2;
        end else if (pick < 88) begin
            send_write(ADDR_DATA, 8'($urandom));
            made = 1;
        end else if (pick < 92) begin
            send_write(ADDR_INDEX, 8'($urandom));
            made = 1;
        end else begin
            send_write(16'($urandom), 8'($urandom));
            made = 1;
        end
        // Now and then pause the source until the block has fully emptied.
        if ($urandom_range(99) == 0) drain();
    endtask

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // Reset pages 0..3, no CHR, default mirroring; stray addresses change nothing.
    task automatic test_reset_values();
        send_write(16'h0000, 8'h00);
        send_write(16'hFFFF, 8'hFF);
        // Index is still zero: this lands in the first CHR low byte.
        send_write(ADDR_DATA, 8'hA5);
        drain();
    endtask

    // CHR low bytes, both mode registers, smallest and largest CHR sizes.
    task automatic test_chr_banks();
        set_config(CFG_CHR_SIZE, 8'd1);
        // Mirror config shows through while the mirror register is untouched.
        set_config(CFG_MIRROR, 8'd1);
        configs_used = configs_used + 1;
        write_reg(REG_CHR1, 8'hFF);
        write_reg(REG_CHR2, 8'h80);
        write_reg(REG_MODE_B, 8'h07);
        write_reg(REG_MODE_A, 8'h01);
        drain();
        set_config(CFG_CHR_SIZE, 8'd255);
        configs_used = configs_used + 1;
        write_reg(REG_CHR3, 8'hE3);
        drain();
    endtask

    // PRG select with zero size (acts as two pages) and the largest size.
    task automatic test_prg_select();
        set_config(CFG_PRG_SIZE, 8'd0);
        configs_used = configs_used + 1;
        write_reg(REG_PRG, 8'h07);
        drain();
        set_config(CFG_PRG_SIZE, 8'd255);
        configs_used = configs_used + 1;
        write_reg(REG_PRG, 8'hFF);
        drain();
    endtask

    // Mirror register overrides the config value for good; high indices are dropped.
    task automatic test_mirror_and_ignored();
        write_reg(REG_MIRROR, 8'h01);
        write_reg(REG_MIRROR, 8'hFE);
        drain();
        set_config(CFG_MIRROR, 8'd0);
        set_config(CFG_UNUSED, 8'hFF);
        configs_used = configs_used + 1;
        write_reg(REG_FIRST_UNUSED, 8'hFF);
        write_reg(REG_LAST_UNUSED, 8'h55);
        drain();
    endtask

    // Hold the sink off for a long stretch while writes keep coming, so the block fills.
    task automatic test_output_stall();
        int made;
        int total;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        total = 0;
        holdoff_req = ~holdoff_req;
        while (total < 30) begin
            random_burst(made);
            total = total + made;
        end
        drain();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [7:0] prg, input logic [7:0] chr,
                                       input int count);
        int made;
        int total;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        configure(prg, chr, 8'($urandom));
        total = 0;
        while (total < count) begin
            random_burst(made);
            total = total + made;
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        holdoff_req = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        writes_sent  = 0;
        maps_checked = 0;
        mismatches   = 0;
        configs_used = 1;
        idle_cycles  = 0;

        // Model state after reset.
        cfg_prg_size = 8'd1;
        cfg_chr_size = 8'd0;
        cfg_mirror   = 1'b0;
        sel_index    = '0;
        mode_a       = 1'b0;
        mode_b       = '0;
        mirror_reg   = 1'b0;
        mirror_seen  = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            chr_low[k] = '0;
            prg_sel[k] = PRG_W'(k);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_chr_banks();
        test_prg_select();
        test_mirror_and_ignored();
        test_output_stall();
        test_random_traffic(11, 64, 8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)), 300);
        test_random_traffic(64, 11, 8'd255, 8'd255, 300);
        test_random_traffic(0, 0, 8'd1, 8'd0, 150);
        test_random_traffic(0, 0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 150);

        // Give any stray result time to show up.
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Covered %0d bus writes and %0d checked mappings over %0d configurations,",
                 writes_sent, maps_checked, configs_used);
        $display("including a long output stall and all mapper register indices.");
        if (mismatches == 0 && pending_maps.size() == 0) begin
            $display("** indexed_bank_switch_mapper_unit: PASSED **");
        end else begin
            $display("** indexed_bank_switch_mapper_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: indexed_bank_switch_mapper_unit.f
+incdir+rtl
rtl/ibsm_pkg.sv
rtl/ibsm_dp.sv
rtl/ibsm_ctrl.sv
rtl/indexed_bank_switch_mapper_unit.sv
test/indexed_bank_switch_mapper_unit_tb.sv
